// File: sv/epaper_refresh_mode_policy_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the refresh mode policy block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EPAPER_REFRESH_MODE_POLICY_TOP_ASSERT_SVH
`define EPAPER_REFRESH_MODE_POLICY_TOP_ASSERT_SVH

// Same-cycle implication
`define EPRMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define EPRMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/eprmp_pkg.sv
// ----------------------------------------------------------------------------
// eprmp_pkg
// Shared types and constants for the refresh mode policy block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eprmp_pkg;

  typedef enum logic [1:0] {
    MODE_FAST  = 2'd0,
    MODE_CLEAN = 2'd1,
    MODE_FULL  = 2'd2,
    MODE_OTHER = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MAX_CONSEC_FAST = 3'd0,
    REG_MAX_FAST_FULL   = 3'd1,
    REG_DEBT_FULL_THR   = 3'd2,
    REG_DEBT_CLEAN_THR  = 3'd3,
    REG_TURBO_MULT      = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ScoreW   = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned MultW    = 4;

  localparam logic [CountW-1:0] MaxConsecFastRst = 8'd8;
  localparam logic [CountW-1:0] MaxFastFullRst   = 8'd32;
  localparam logic [ScoreW-1:0] DebtFullThrRst   = 16'd4000;
  localparam logic [ScoreW-1:0] DebtCleanThrRst  = 16'd2000;
  localparam logic [MultW-1:0]  TurboMultRst     = 4'd2;

  typedef struct packed {
    logic [CountW-1:0] max_consec_fast;
    logic [CountW-1:0] max_fast_full;
    logic [ScoreW-1:0] debt_full_thr;
    logic [ScoreW-1:0] debt_clean_thr;
    logic [MultW-1:0]  turbo_mult;
  } cfg_t;

endpackage

// File: sv/eprmp_cfg.sv
// ----------------------------------------------------------------------------
// eprmp_cfg
// Configuration register file with write decode and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eprmp_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [eprmp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [eprmp_pkg::CfgDataW-1:0]      cfg_data_i,
  output eprmp_pkg::cfg_t                     cfg_o
);
  import eprmp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MAX_CONSEC_FAST: cfg_d.max_consec_fast = cfg_data_i[CountW-1:0];
        REG_MAX_FAST_FULL:   cfg_d.max_fast_full   = cfg_data_i[CountW-1:0];
        REG_DEBT_FULL_THR:   cfg_d.debt_full_thr   = cfg_data_i[ScoreW-1:0];
        REG_DEBT_CLEAN_THR:  cfg_d.debt_clean_thr  = cfg_data_i[ScoreW-1:0];
        REG_TURBO_MULT:      cfg_d.turbo_mult      = cfg_data_i[MultW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_consec_fast <= MaxConsecFastRst;
      cfg_q.max_fast_full   <= MaxFastFullRst;
      cfg_q.debt_full_thr   <= DebtFullThrRst;
      cfg_q.debt_clean_thr  <= DebtCleanThrRst;
      cfg_q.turbo_mult      <= TurboMultRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/eprmp_policy.sv
// ----------------------------------------------------------------------------
// eprmp_policy
// Mode decision and the fast-run, fast-since-full and ink debt state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "epaper_refresh_mode_policy_top_assert.svh"

module eprmp_policy #(
  parameter int unsigned CLEAN_DIVISOR = 4,
  parameter int unsigned SCORE_CEILING = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  eprmp_pkg::mode_e                  req_mode_i,
  input  logic [eprmp_pkg::ScoreW-1:0]      ink_score_i,
  input  logic                              turbo_i,
  input  eprmp_pkg::cfg_t                   cfg_i,
  output eprmp_pkg::mode_e                  chosen_o
);
  import eprmp_pkg::*;

  localparam int unsigned ProdW    = ScoreW + MultW;
  localparam int unsigned DivShift = ScoreW + 5;
  localparam int unsigned DivMulW  = DivShift + 1;
  localparam logic [ProdW-1:0]   CeilW  = ProdW'(SCORE_CEILING);
  localparam logic [DivMulW-1:0] DivMul =
    DivMulW'(((64'd1 << DivShift) + 64'(CLEAN_DIVISOR) - 64'd1) / 64'(CLEAN_DIVISOR));

  logic [CountW-1:0] run_q, run_d;
  logic [CountW-1:0] since_q, since_d;
  logic [ScoreW-1:0] debt_q, debt_d;

  logic [ProdW-1:0]          scaled;
  logic [ScoreW-1:0]         score;
  logic [ScoreW:0]           projected;
  logic [ScoreW+DivMulW-1:0] div_prod;
  logic [ScoreW-1:0]         debt_div;
  mode_e                     chosen;

  always_comb begin
    scaled    = turbo_i ? ink_score_i * cfg_i.turbo_mult : {{MultW{1'b0}}, ink_score_i};
    score     = (scaled > CeilW) ? CeilW[ScoreW-1:0] : scaled[ScoreW-1:0];
    projected = {1'b0, debt_q} + {1'b0, score};
    div_prod  = debt_q * DivMul;
    debt_div  = div_prod[DivShift +: ScoreW];

    chosen = req_mode_i;
    if (req_mode_i == MODE_FAST) begin
      if (since_q >= cfg_i.max_fast_full) begin
        chosen = MODE_FULL;
      end else if (run_q >= cfg_i.max_consec_fast) begin
        chosen = MODE_CLEAN;
      end else if (projected >= {1'b0, cfg_i.debt_full_thr}) begin
        chosen = MODE_FULL;
      end else if (projected >= {1'b0, cfg_i.debt_clean_thr}) begin
        chosen = MODE_CLEAN;
      end
    end

    run_d   = run_q;
    since_d = since_q;
    debt_d  = debt_q;
    if (fire_i) begin
      case (chosen)
        MODE_FAST: begin
          run_d   = (run_q == '1) ? run_q : run_q + CountW'(1);
          since_d = (since_q == '1) ? since_q : since_q + CountW'(1);
          debt_d  = projected[ScoreW] ? '1 : projected[ScoreW-1:0];
        end
        MODE_FULL: begin
          run_d   = '0;
          since_d = '0;
          debt_d  = '0;
        end
        default: begin
          run_d  = '0;
          debt_d = debt_div;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      since_q <= '0;
      debt_q  <= '0;
    end else begin
      run_q   <= run_d;
      since_q <= since_d;
      debt_q  <= debt_d;
    end
  end

  assign chosen_o = chosen;

  `EPRMP_ASSERT_NOW(a_fast_only_on_request, fire_i && chosen == MODE_FAST, req_mode_i == MODE_FAST, "fast chosen without fast request")
  `EPRMP_ASSERT_NEXT(a_full_clears, fire_i && chosen == MODE_FULL, debt_q == '0 && since_q == '0 && run_q == '0, "full pass left state")
  `EPRMP_ASSERT_NEXT(a_clean_shrinks, fire_i && chosen != MODE_FAST, debt_q <= $past(debt_q) && run_q == '0, "slow pass did not shrink debt")

endmodule

// File: sv/epaper_refresh_mode_policy_top.sv
// ----------------------------------------------------------------------------
// epaper_refresh_mode_policy_top: refresh mode policy
// One item per cycle sustained while out_stall_i does not hold the result register.
// Input register feeds the decision logic, which updates state and loads the result register.
// Reset clears counters, debt and valids (not the data registers); config registers take their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epaper_refresh_mode_policy_top #(
  parameter int unsigned CLEAN_DIVISOR = 4,
  parameter int unsigned SCORE_CEILING = 1000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [eprmp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [eprmp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      requested_mode_i,
  input  logic [15:0]                     ink_score_i,
  input  logic                            turbo_pass_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      chosen_mode_o
);
  import eprmp_pkg::*;

  cfg_t  cfg;
  mode_e chosen;

  logic              s1_valid_q;
  mode_e             s1_mode_q;
  logic [ScoreW-1:0] s1_score_q;
  logic              s1_turbo_q;
  logic              out_valid_q;
  mode_e             out_mode_q;

  logic out_free;
  logic fire;
  logic in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  eprmp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  eprmp_policy #(
    .CLEAN_DIVISOR (CLEAN_DIVISOR),
    .SCORE_CEILING (SCORE_CEILING)
  ) u_policy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_mode_i  (s1_mode_q),
    .ink_score_i (s1_score_q),
    .turbo_i     (s1_turbo_q),
    .cfg_i       (cfg),
    .chosen_o    (chosen)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_mode_q  <= mode_e'(requested_mode_i);
      s1_score_q <= ink_score_i;
      s1_turbo_q <= turbo_pass_i;
    end
    if (fire) begin
      out_mode_q <= chosen;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_mode_o = out_mode_q;

endmodule
